/* hw/rtl/segment_quad_intersection_unit_defines.svh */
// Assertion macros for the segment against quad intersection unit.
// Used by segment_quad_intersection_unit.sv; relies on clk_i and rst_ni in scope.
`ifndef SEGMENT_QUAD_INTERSECTION_UNIT_DEFINES_SVH
`define SEGMENT_QUAD_INTERSECTION_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SQI_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SQI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/sqi_pkg.sv */
// Widths and types shared by the segment against quad intersection unit.
// No dependencies.
package sqi_pkg;
  localparam int CoordW = 16;             // Q7.8 coordinate
  localparam int DiffW  = CoordW + 1;     // difference of two coordinates
  localparam int NrmW   = 2 * DiffW + 1;  // face normal component
  localparam int DotW   = NrmW + DiffW + 2; // num and den
  localparam int DenW   = DotW - 1;       // magnitude of den
  localparam int LoW    = 27;             // low slice of den and num
  localparam int HiW    = DenW - LoW;     // high slice of den and num
  localparam int PpW    = DiffW + LoW + 1; // partial products of the hit point
  localparam int XW     = DenW + CoordW + 2; // signed numerator of the hit point
  localparam int RemW   = XW - 1;         // divider remainder
  localparam int QW     = CoordW;         // quotient bits, one per divider stage
  localparam int GW     = DiffW + NrmW + 1; // edge vector crossed with the normal
  localparam int GLoW   = 26;
  localparam int GHiW   = GW - GLoW;
  localparam int PeW    = DiffW + GHiW;   // partial products of the edge tests
  localparam int TW     = PeW + GLoW + 4; // edge test sum
  localparam int CornerW = 3 * CoordW;
  localparam int NumCorners = 4;
  localparam int CfgIdxW = 2;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [NrmW-1:0]   nrm_t;
  typedef logic signed [DotW-1:0]   dot_t;
  typedef logic signed [PpW-1:0]    pp_t;
  typedef logic signed [XW-1:0]     x_t;
  typedef logic signed [GW-1:0]     g_t;
  typedef logic signed [PeW-1:0]    pe_t;
  typedef logic signed [TW-1:0]     t_t;

  // Per-item flags that travel down the pipeline.
  typedef struct packed {
    logic degen;
    logic miss;
  } flags_t;
endpackage

/* hw/rtl/segment_quad_intersection_unit.sv */
// Segment against quad intersection test, fully pipelined.
// Depends on sqi_pkg and segment_quad_intersection_unit_defines.svh.
//
// Each input beat carries a segment (start and end points, signed Q7.8) and
// gives one output beat: hit and degenerate-face flags in tuser and the hit
// point in tdata, zero on a miss. The quad's corners sit in four 48-bit
// registers. One beat is accepted every cycle unless the output stalls; the
// hit point comes from a restoring divider, one quotient bit per stage. The
// whole pipeline stalls together while a result waits at the output. A segment
// may follow a corner write in the next cycle.
`include "segment_quad_intersection_unit_defines.svh"

module segment_quad_intersection_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [sqi_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sqi_pkg::CornerW-1:0] cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_x, hit_y, hit_z
  output logic [47:0]  m_axis_tdata,
  // hit, degenerate_face
  output logic [1:0]   m_axis_tuser
);
  localparam int CW = sqi_pkg::CoordW;
  localparam int QW = sqi_pkg::QW;

  logic en;
  logic out_v_q;
  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // Corner registers and the values derived from them.
  logic [sqi_pkg::NumCorners-1:0][sqi_pkg::CornerW-1:0] corner_q;
  sqi_pkg::coord_t cq [4][3];
  sqi_pkg::diff_t ab [3], ac [3], fe [4][3];
  sqi_pkg::nrm_t n_d [3], n_q [3];
  sqi_pkg::g_t g_d [4][3], g_q [4][3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 3; k++) begin
        cq[i][k] = sqi_pkg::coord_t'(corner_q[i][k*CW +: CW]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      ab[k] = sqi_pkg::diff_t'(cq[1][k]) - sqi_pkg::diff_t'(cq[0][k]);
      ac[k] = sqi_pkg::diff_t'(cq[2][k]) - sqi_pkg::diff_t'(cq[0][k]);
    end
    for (int k = 0; k < 3; k++) begin
      n_d[k] = sqi_pkg::nrm_t'(ab[(k+1)%3]) * sqi_pkg::nrm_t'(ac[(k+2)%3])
             - sqi_pkg::nrm_t'(ab[(k+2)%3]) * sqi_pkg::nrm_t'(ac[(k+1)%3]);
    end
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 3; k++) begin
        fe[i][k] = sqi_pkg::diff_t'(cq[(i+1)%4][k]) - sqi_pkg::diff_t'(cq[i][k]);
      end
      for (int k = 0; k < 3; k++) begin
        g_d[i][k] = sqi_pkg::g_t'(fe[i][(k+1)%3]) * sqi_pkg::g_t'(n_q[(k+2)%3])
                  - sqi_pkg::g_t'(fe[i][(k+2)%3]) * sqi_pkg::g_t'(n_q[(k+1)%3]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= '0;
      for (int k = 0; k < 3; k++) n_q[k] <= '0;
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) g_q[i][k] <= '0;
      end
    end else begin
      if (cfg_we_i) corner_q[cfg_idx_i] <= cfg_data_i;
      n_q <= n_d;
      g_q <= g_d;
    end
  end

  // Stage 1: input differences.
  logic s1_v_q;
  sqi_pkg::coord_t s1_s_q [3];
  sqi_pkg::diff_t s1_ed_q [3], s1_as_q [3];
  // Stage 2: normal products.
  logic s2_v_q;
  sqi_pkg::flags_t s2_f_q;
  sqi_pkg::dot_t s2_pd_q [3], s2_pn_q [3];
  sqi_pkg::coord_t s2_s_q [3];
  sqi_pkg::diff_t s2_ed_q [3];
  // Stage 3: den and num.
  logic s3_v_q;
  sqi_pkg::flags_t s3_f_q;
  sqi_pkg::dot_t s3_den_q, s3_num_q;
  sqi_pkg::coord_t s3_s_q [3];
  sqi_pkg::diff_t s3_ed_q [3];
  // Stage 4: den made positive.
  logic s4_v_q, s4_zero_q;
  sqi_pkg::flags_t s4_f_q;
  sqi_pkg::dot_t s4_den_q, s4_num_q;
  sqi_pkg::coord_t s4_s_q [3];
  sqi_pkg::diff_t s4_ed_q [3];
  // Stage 5: range check and partial products.
  logic s5_v_q;
  sqi_pkg::flags_t s5_f_q;
  logic [sqi_pkg::DenW-1:0] s5_den_q;
  sqi_pkg::pp_t s5_sl_q [3], s5_sh_q [3], s5_el_q [3], s5_eh_q [3];
  // Stage 6: signed numerator of the hit point.
  logic s6_v_q;
  sqi_pkg::flags_t s6_f_q;
  logic [sqi_pkg::DenW-1:0] s6_den_q;
  sqi_pkg::x_t s6_x_q [3];
  // Divider stages; index 0 is the magnitude stage.
  logic dv_v_q [QW+1];
  sqi_pkg::flags_t dv_f_q [QW+1];
  logic [sqi_pkg::DenW-1:0] dv_den_q [QW+1];
  logic [sqi_pkg::RemW-1:0] dv_rem_q [QW+1][3];
  logic [QW-1:0] dv_quo_q [QW+1][3];
  logic dv_neg_q [QW+1][3];
  logic [sqi_pkg::RemW-1:0] dv_cand [QW];
  // Hit point and offsets from the corners.
  logic h_v_q;
  sqi_pkg::flags_t h_f_q;
  sqi_pkg::coord_t h_hp_q [3];
  sqi_pkg::diff_t h_d_q [4][3];
  // Edge test partial products.
  logic e2_v_q;
  sqi_pkg::flags_t e2_f_q;
  sqi_pkg::coord_t e2_hp_q [3];
  sqi_pkg::pe_t e2_lo_q [4][3], e2_hi_q [4][3];
  // Edge test sums.
  logic e3_v_q;
  sqi_pkg::flags_t e3_f_q;
  sqi_pkg::coord_t e3_hp_q [3];
  sqi_pkg::t_t e3_t_q [4];
  // Output register.
  logic [1:0] out_user_q;
  logic [47:0] out_data_q;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; s2_v_q <= 1'b0; s3_v_q <= 1'b0; s4_v_q <= 1'b0;
      s5_v_q <= 1'b0; s6_v_q <= 1'b0;
      for (int j = 0; j <= QW; j++) dv_v_q[j] <= 1'b0;
      h_v_q <= 1'b0; e2_v_q <= 1'b0; e3_v_q <= 1'b0; out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s_axis_tvalid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
      dv_v_q[0] <= s6_v_q;
      for (int j = 0; j < QW; j++) dv_v_q[j+1] <= dv_v_q[j];
      h_v_q <= dv_v_q[QW];
      e2_v_q <= h_v_q;
      e3_v_q <= e2_v_q;
      out_v_q <= e3_v_q;
    end
  end

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      dv_cand[j] = sqi_pkg::RemW'(dv_den_q[j]) << (QW - 1 - j);
    end
  end

  // Front stages and the divider.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_s_q[k]  <= sqi_pkg::coord_t'(s_axis_tdata[k*CW +: CW]);
        s1_ed_q[k] <= sqi_pkg::diff_t'(sqi_pkg::coord_t'(s_axis_tdata[(3+k)*CW +: CW]))
                    - sqi_pkg::diff_t'(sqi_pkg::coord_t'(s_axis_tdata[k*CW +: CW]));
        s1_as_q[k] <= sqi_pkg::diff_t'(cq[0][k])
                    - sqi_pkg::diff_t'(sqi_pkg::coord_t'(s_axis_tdata[k*CW +: CW]));
      end

      s2_f_q.degen <= (n_q[0] == '0) && (n_q[1] == '0) && (n_q[2] == '0);
      s2_f_q.miss  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        s2_pd_q[k] <= sqi_pkg::dot_t'(n_q[k]) * sqi_pkg::dot_t'(s1_ed_q[k]);
        s2_pn_q[k] <= sqi_pkg::dot_t'(n_q[k]) * sqi_pkg::dot_t'(s1_as_q[k]);
      end
      s2_s_q <= s1_s_q;
      s2_ed_q <= s1_ed_q;

      s3_f_q <= s2_f_q;
      s3_den_q <= s2_pd_q[0] + s2_pd_q[1] + s2_pd_q[2];
      s3_num_q <= s2_pn_q[0] + s2_pn_q[1] + s2_pn_q[2];
      s3_s_q <= s2_s_q;
      s3_ed_q <= s2_ed_q;

      s4_f_q <= s3_f_q;
      s4_zero_q <= (s3_den_q == '0);
      s4_den_q <= s3_den_q[sqi_pkg::DotW-1] ? -s3_den_q : s3_den_q;
      s4_num_q <= s3_den_q[sqi_pkg::DotW-1] ? -s3_num_q : s3_num_q;
      s4_s_q <= s3_s_q;
      s4_ed_q <= s3_ed_q;

      // A parameter outside 0 to 1 is a miss; its products are then don't-care.
      s5_f_q.degen <= s4_f_q.degen;
      s5_f_q.miss  <= s4_zero_q || s4_num_q[sqi_pkg::DotW-1] || (s4_num_q > s4_den_q);
      s5_den_q <= s4_den_q[sqi_pkg::DenW-1:0];
      for (int k = 0; k < 3; k++) begin
        s5_sl_q[k] <= sqi_pkg::pp_t'(s4_s_q[k])
                    * sqi_pkg::pp_t'({1'b0, s4_den_q[sqi_pkg::LoW-1:0]});
        s5_sh_q[k] <= sqi_pkg::pp_t'(s4_s_q[k])
                    * sqi_pkg::pp_t'({1'b0, s4_den_q[sqi_pkg::DenW-1:sqi_pkg::LoW]});
        s5_el_q[k] <= sqi_pkg::pp_t'(s4_ed_q[k])
                    * sqi_pkg::pp_t'({1'b0, s4_num_q[sqi_pkg::LoW-1:0]});
        s5_eh_q[k] <= sqi_pkg::pp_t'(s4_ed_q[k])
                    * sqi_pkg::pp_t'({1'b0, s4_num_q[sqi_pkg::DenW-1:sqi_pkg::LoW]});
      end

      s6_f_q <= s5_f_q;
      s6_den_q <= s5_den_q;
      for (int k = 0; k < 3; k++) begin
        s6_x_q[k] <= sqi_pkg::x_t'(s5_sl_q[k]) + (sqi_pkg::x_t'(s5_sh_q[k]) <<< sqi_pkg::LoW)
                   + sqi_pkg::x_t'(s5_el_q[k]) + (sqi_pkg::x_t'(s5_eh_q[k]) <<< sqi_pkg::LoW);
      end

      dv_f_q[0] <= s6_f_q;
      dv_den_q[0] <= s6_den_q;
      for (int k = 0; k < 3; k++) begin
        dv_neg_q[0][k] <= s6_x_q[k][sqi_pkg::XW-1];
        dv_rem_q[0][k] <= s6_x_q[k][sqi_pkg::XW-1] ? sqi_pkg::RemW'(-s6_x_q[k])
                                                   : sqi_pkg::RemW'(s6_x_q[k]);
        dv_quo_q[0][k] <= '0;
      end

      // Restoring divider: stage j settles quotient bit QW-1-j for all three axes.
      for (int j = 0; j < QW; j++) begin
        dv_f_q[j+1] <= dv_f_q[j];
        dv_den_q[j+1] <= dv_den_q[j];
        for (int k = 0; k < 3; k++) begin
          dv_neg_q[j+1][k] <= dv_neg_q[j][k];
          if (dv_rem_q[j][k] >= dv_cand[j]) begin
            dv_rem_q[j+1][k] <= dv_rem_q[j][k] - dv_cand[j];
            dv_quo_q[j+1][k] <= dv_quo_q[j][k] | (QW'(1) << (QW - 1 - j));
          end else begin
            dv_rem_q[j+1][k] <= dv_rem_q[j][k];
            dv_quo_q[j+1][k] <= dv_quo_q[j][k];
          end
        end
      end
    end
  end

  // Back stages: the edge test ((P - q_i) x f_i) . n is taken as (P - q_i) . (f_i x n).
  sqi_pkg::diff_t hps [3];
  sqi_pkg::coord_t hp [3];
  logic edge_ok [4];
  logic hit;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hps[k] = dv_neg_q[QW][k] ? -sqi_pkg::diff_t'({1'b0, dv_quo_q[QW][k]})
                               : sqi_pkg::diff_t'({1'b0, dv_quo_q[QW][k]});
      hp[k] = hps[k][CW-1:0];
    end
    for (int i = 0; i < 4; i++) begin
      edge_ok[i] = e3_t_q[i][sqi_pkg::TW-1] || (e3_t_q[i] == '0);
    end
    hit = !e3_f_q.degen && !e3_f_q.miss && edge_ok[0] && edge_ok[1] && edge_ok[2] && edge_ok[3];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_f_q <= dv_f_q[QW];
      h_hp_q <= hp;
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) begin
          h_d_q[i][k] <= sqi_pkg::diff_t'(hp[k]) - sqi_pkg::diff_t'(cq[i][k]);
        end
      end

      e2_f_q <= h_f_q;
      e2_hp_q <= h_hp_q;
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) begin
          e2_lo_q[i][k] <= sqi_pkg::pe_t'(h_d_q[i][k])
                         * sqi_pkg::pe_t'({1'b0, g_q[i][k][sqi_pkg::GLoW-1:0]});
          e2_hi_q[i][k] <= sqi_pkg::pe_t'(h_d_q[i][k])
                         * sqi_pkg::pe_t'($signed(g_q[i][k][sqi_pkg::GW-1:sqi_pkg::GLoW]));
        end
      end

      e3_f_q <= e2_f_q;
      e3_hp_q <= e2_hp_q;
      for (int i = 0; i < 4; i++) begin
        e3_t_q[i] <= sqi_pkg::t_t'(e2_lo_q[i][0]) + sqi_pkg::t_t'(e2_lo_q[i][1])
                   + sqi_pkg::t_t'(e2_lo_q[i][2])
                   + ((sqi_pkg::t_t'(e2_hi_q[i][0]) + sqi_pkg::t_t'(e2_hi_q[i][1])
                     + sqi_pkg::t_t'(e2_hi_q[i][2])) <<< sqi_pkg::GLoW);
      end

      out_user_q <= {e3_f_q.degen, hit};
      out_data_q <= hit ? {e3_hp_q[2], e3_hp_q[1], e3_hp_q[0]} : '0;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tdata  = out_data_q;

  `SQI_ASSERT_IMPLIES(a_hit_not_degen, out_v_q && out_user_q[0], !out_user_q[1], "degen hit")
  `SQI_ASSERT_IMPLIES(a_miss_zero, out_v_q && !out_user_q[0], out_data_q == '0, "miss point")
  `SQI_ASSERT_NEXT(a_front_flow, en && s_axis_tvalid, s1_v_q, "beat not in first stage")
endmodule

/* tb/testbench.sv */
// Self-checking testbench for segment_quad_intersection_unit.
// Depends on sqi_pkg; predicts each segment/quad result exactly and checks every output beat.
`timescale 1ns / 1ps

module testbench;
  localparam int CoordW = sqi_pkg::CoordW;
  localparam int CornerW = sqi_pkg::CornerW;
  localparam int NumCorners = sqi_pkg::NumCorners;
  localparam int CfgIdxW = sqi_pkg::CfgIdxW;
  typedef sqi_pkg::coord_t coord_t;

  typedef logic signed [127:0] wide_t;

  typedef enum logic [CfgIdxW-1:0] {
    CORNER_A = 2'd0,
    CORNER_B = 2'd1,
    CORNER_C = 2'd2,
    CORNER_D = 2'd3
  } corner_idx_e;

  typedef struct packed {
    logic   hit;
    logic   degen;
    coord_t x;
    coord_t y;
    coord_t z;
  } crossing_t;

  localparam int MaxGap = 18;
  localparam int LongHold = 400;
  localparam int Latency = 27;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CornerW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  logic [CornerW-1:0] quad_corner [NumCorners];
  crossing_t expected_q [$];
  int errors = 0;
  int cycles = 0;
  bit steady = 0;      // no idling on either side while set
  bit hold_request = 0;

  segment_quad_intersection_unit DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void cross3(input wide_t u0, u1, u2, v0, v1, v2,
                                 output wide_t r0, r1, r2);
    r0 = u1 * v2 - u2 * v1;
    r1 = u2 * v0 - u0 * v2;
    r2 = u0 * v1 - u1 * v0;
  endfunction

  function automatic crossing_t predict_crossing(input logic [95:0] seg);
    wide_t q [4][3];
    wide_t s [3], ed [3], as [3], n [3], hp [3], d [3], f [3], c [3];
    wide_t ab [3], ac [3];
    wide_t num, den, x, t;
    crossing_t r;
    r = '0;
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++) q[i][k] = coord_t'(quad_corner[i][CoordW*k +: CoordW]);
    for (int k = 0; k < 3; k++) begin
      s[k] = coord_t'(seg[CoordW*k +: CoordW]);
      ed[k] = wide_t'(coord_t'(seg[CoordW*(k+3) +: CoordW])) - s[k];
      ab[k] = q[1][k] - q[0][k];
      ac[k] = q[2][k] - q[0][k];
      as[k] = q[0][k] - s[k];
    end
    cross3(ab[0], ab[1], ab[2], ac[0], ac[1], ac[2], n[0], n[1], n[2]);
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
      r.degen = 1'b1;
      return r;
    end
    den = n[0] * ed[0] + n[1] * ed[1] + n[2] * ed[2];
    num = n[0] * as[0] + n[1] * as[1] + n[2] * as[2];
    if (den == 0) return r;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num < 0 || num > den) return r;
    // Signed division truncates toward zero, as the hit point requires.
    for (int k = 0; k < 3; k++) begin
      x = den * s[k] + num * ed[k];
      hp[k] = coord_t'(x / den);
    end
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 3; k++) begin
        d[k] = hp[k] - q[i][k];
        f[k] = q[(i + 1) % 4][k] - q[i][k];
      end
      cross3(d[0], d[1], d[2], f[0], f[1], f[2], c[0], c[1], c[2]);
      t = c[0] * n[0] + c[1] * n[1] + c[2] * n[2];
      if (t > 0) return r;
    end
    r.hit = 1'b1;
    r.x = coord_t'(hp[0]);
    r.y = coord_t'(hp[1]);
    r.z = coord_t'(hp[2]);
    return r;
  endfunction

  // Receiver: random stalls, with one long hold-off when requested.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = steady ? 0 : $urandom_range(0, MaxGap);
      if (hold_request) begin
        hold_request = 0;
        gap = LongHold;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Checks every output beat against the oldest prediction.
  always @(posedge clk_i) begin
    crossing_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("output beat with no prediction waiting");
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tuser[0] !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] !== want.degen) begin
          $error("degenerate_face: expected %0d, got %0d", want.degen, m_axis_tuser[1]);
          errors++;
        end
        if (m_axis_tdata[15:0] !== want.x) begin
          $error("hit_x: expected %0d, got %0d", want.x, $signed(m_axis_tdata[15:0]));
          errors++;
        end
        if (m_axis_tdata[31:16] !== want.y) begin
          $error("hit_y: expected %0d, got %0d", want.y, $signed(m_axis_tdata[31:16]));
          errors++;
        end
        if (m_axis_tdata[47:32] !== want.z) begin
          $error("hit_z: expected %0d, got %0d", want.z, $signed(m_axis_tdata[47:32]));
          errors++;
        end
      end
    end
  end

  // Sends one segment; valid stays high into the next beat when no gap follows.
  task automatic send_segment(input int sx, sy, sz, ex, ey, ez);
    int gap;
    logic [95:0] seg;
    gap = steady ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    seg = {ez[15:0], ey[15:0], ex[15:0], sz[15:0], sy[15:0], sx[15:0]};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= seg;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q = {expected_q, predict_crossing(seg)};
  endtask

  task automatic drain();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_corner(input corner_idx_e idx, input int x, y, z);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= {z[15:0], y[15:0], x[15:0]};
    quad_corner[idx] = {z[15:0], y[15:0], x[15:0]};
    @(posedge clk_i);
  endtask

  task automatic set_quad(input int ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz);
    drain();
    write_corner(CORNER_A, ax, ay, az);
    write_corner(CORNER_B, bx, by, bz);
    write_corner(CORNER_C, cx, cy, cz);
    write_corner(CORNER_D, dx, dy, dz);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_noise();
    send_segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic test_zero_face();
    send_segment(0, 0, -256, 0, 0, 256);
    send_segment(-32768, -32768, -32768, 32767, 32767, 32767);
    send_segment(32767, 32767, 32767, -32768, -32768, -32768);
  endtask

  task automatic test_unit_square();
    set_quad(-256, -256, 0, 256, -256, 0, 256, 256, 0, -256, 256, 0);
    send_segment(0, 0, -256, 0, 0, 256);        // straight through the centre
    send_segment(0, 0, 256, 0, 0, -256);        // same, opposite direction
    send_segment(100, -50, -300, -77, 33, 500); // oblique, truncated hit point
    send_segment(256, 0, -256, 256, 0, 256);    // on an edge
    send_segment(256, 256, -10, 256, 256, 10);  // on a corner
    send_segment(0, 0, 0, 0, 0, 256);           // starts on the face
    send_segment(0, 0, -256, 0, 0, 0);          // ends on the face
    send_segment(0, 0, 10, 0, 0, 256);          // face behind the segment
    send_segment(0, 0, -256, 0, 0, -1);         // face beyond the segment
    send_segment(-100, 0, 50, 100, 0, 50);      // parallel to the face
    send_segment(-100, 0, 0, 100, 0, 0);        // lying in the face
    send_segment(10, 10, 10, 10, 10, 10);       // zero length
    send_segment(1000, 0, -256, 1000, 0, 256);  // misses outside
    send_segment(257, 0, -256, 257, 0, 256);    // just outside an edge
  endtask

  task automatic test_extreme_corners();
    set_quad(-32768, -32768, 0, 32767, -32768, 0, 32767, 32767, 0, -32768, 32767, 0);
    send_segment(-32768, -32768, -32768, 32767, 32767, 32767);
    send_segment(32767, -32768, 32767, -32768, 32767, -32768);
    send_segment(32767, 32767, -32768, 32767, 32767, 32767);
    send_segment(-32768, 32767, 32767, -32768, 32767, -32768);
    set_quad(-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, -32768,
             32767, -32768, 32767);
    send_segment(-32768, 32767, 32767, 32767, -32768, -32768);
    send_segment(0, 0, -32768, 0, 0, 32767);
    // Collinear corners give a zero normal with nonzero coordinates.
    set_quad(-100, -100, -100, 0, 0, 0, 100, 100, 100, 5, 5, 5);
    send_segment(0, 0, -256, 0, 0, 256);
  endtask

  // Mostly segments aimed through a random parallelogram, some noise; without convex, the fourth corner is random.
  task automatic test_random_quad(input int count, input bit convex);
    int a [3], e1 [3], e2 [3], d [3], p [3], w [3];
    int u, v, k1, k2;
    for (int k = 0; k < 3; k++) begin
      a[k] = $urandom_range(0, 8000) - 4000;
      e1[k] = $urandom_range(0, 4000) - 2000;
      e2[k] = $urandom_range(0, 4000) - 2000;
      d[k] = convex ? a[k] + e2[k] : $urandom_range(0, 8000) - 4000;
    end
    set_quad(a[0], a[1], a[2], a[0] + e1[0], a[1] + e1[1], a[2] + e1[2],
             a[0] + e1[0] + e2[0], a[1] + e1[1] + e2[1], a[2] + e1[2] + e2[2],
             d[0], d[1], d[2]);
    repeat (count) begin
      if ($urandom_range(0, 9) < 3) begin
        send_noise();
      end else begin
        u = $urandom_range(0, 64);
        v = $urandom_range(0, 64);
        k1 = $urandom_range(0, 32);
        k2 = $urandom_range(0, 32);
        for (int k = 0; k < 3; k++) begin
          p[k] = a[k] + (u * e1[k] + v * e2[k]) / 64;
          w[k] = $urandom_range(0, 6000) - 3000;
        end
        send_segment(p[0] - w[0] * k1 / 16, p[1] - w[1] * k1 / 16, p[2] - w[2] * k1 / 16,
                     p[0] + w[0] * k2 / 16, p[1] + w[1] * k2 / 16, p[2] + w[2] * k2 / 16);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NumCorners; i++) quad_corner[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_face();
    test_unit_square();
    test_extreme_corners();
    test_random_quad(110, 1);
    hold_request = 1;
    test_random_quad(110, 1);
    steady = 1;
    test_random_quad(110, 1);
    steady = 0;
    test_random_quad(110, 0);
    test_random_quad(110, 1);
    test_random_quad(110, 1);
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/sqi_pkg.sv
hw/rtl/segment_quad_intersection_unit.sv
tb/testbench.sv
